// ===== sv/fixed_latency_memory_responder_core_defines.svh =====
// Assertion helpers for the fixed latency memory responder.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef FIXED_LATENCY_MEMORY_RESPONDER_CORE_DEFINES_SVH
`define FIXED_LATENCY_MEMORY_RESPONDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is applied.
`define FLR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define FLR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/flr_pkg.sv =====
package flr_pkg;

  localparam int unsigned REQ_DEPTH   = 16;
  localparam int unsigned RESP_DEPTH  = 16;
  localparam int unsigned MAX_CREDITS = 255;

  localparam int unsigned REQ_AW  = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;
  localparam int unsigned RESP_AW = (RESP_DEPTH > 1) ? $clog2(RESP_DEPTH) : 1;
  localparam int unsigned REQ_CW  = $clog2(REQ_DEPTH + 1);
  localparam int unsigned RESP_CW = $clog2(RESP_DEPTH + 1);
  localparam int unsigned CRED_W  = $clog2(MAX_CREDITS + 1);

  localparam int unsigned CQ_DEPTH = 2;
  localparam int unsigned CQ_AW    = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int unsigned CQ_CW    = $clog2(CQ_DEPTH + 1);

  localparam int unsigned WORD_W      = 64;
  localparam int unsigned LAT_W       = 16;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [2:0] ORIGIN_L2 = 3'd2;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_CREDIT  = 2'd1,
    OP_TICK    = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RK_CREDIT     = 2'd0,
    RK_RESPONSE   = 2'd1,
    RK_BAD_ORIGIN = 2'd2,
    RK_OVERFLOW   = 2'd3
  } rk_e;

  typedef enum logic [1:0] {
    CMD_REQ    = 2'd0,
    CMD_BAD    = 2'd1,
    CMD_CREDIT = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LATENCY = 3'd0,
    CFG_NODE    = 3'd1,
    CFG_APP     = 3'd2,
    CFG_PACKETS = 3'd3,
    CFG_FLITS   = 3'd4
  } cfg_idx_e;

  // Request word: address 31:0, length 47:32, node 55:48, app 59:56,
  // kind 61:60, level two hit 62, roundtrip mark 63.
  typedef struct packed {
    cmd_e              kind;
    logic [WORD_W-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [LAT_W-1:0] latency;
    logic [7:0]       packets;
    logic [7:0]       flits;
  } cfg_t;

  typedef struct packed {
    rk_e         kind;
    logic [7:0]  dst_node;
    logic [3:0]  dst_app;
    logic [1:0]  resp_kind;
    logic        resp_l2_hit;
    logic [31:0] resp_address;
    logic [15:0] resp_length;
    logic        resp_roundtrip;
    logic [7:0]  resp_packets;
    logic [7:0]  resp_flits;
  } result_t;

  typedef struct packed {
    logic [REQ_CW-1:0]  req_count;
    logic [RESP_CW-1:0] resp_count;
    logic [CRED_W-1:0]  held;
    logic               armed;
    logic               tick_read;
    logic               credit_read;
  } status_t;

endpackage

// ===== sv/fixed_latency_memory_responder_core.sv =====
// Fixed latency memory responder. Each input transaction is a request, an output credit or a
// time tick, selected by s_axis_tuser_i; every transaction gives at most one output
// transaction, whose kind is on m_axis_tuser_o: an ingress credit for an accepted request, an
// error for a request from a level other than two or one that finds the request queue full,
// or a response. A response is due when the latency timer runs out on time ticks; it leaves
// at once if an output credit is held, else when the next credit arrives. The input side
// takes a transaction whenever the two-entry command queue has room. The executing side
// handles one command at a time: a request, an error, a saved credit or a non-expiring tick
// ends in ST_IDLE, while a retiring tick or a credit that releases a queued response also
// passes ST_TICK_RD or ST_CRED_RD, as the request and response queues are RAMs with
// registered reads. A command waits while the output register holds an untaken transaction.
// No clearing pass runs after reset; the block is ready as soon as reset is released.
module fixed_latency_memory_responder_core import flr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration writes.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  // Input stream.
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // operation[1:0]
  input  logic [1:0]             s_axis_tuser_i,
  // req_origin[2:0], req_node[10:3], req_app[14:11], req_kind[16:15], req_l2_hit[17],
  // req_address[49:18], req_length[65:50], req_roundtrip[66], zero[71:67]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // Output stream.
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // result_kind[1:0]
  output logic [1:0]             m_axis_tuser_o,
  // dst_node[7:0], dst_app[11:8], resp_kind[13:12], resp_l2_hit[14], resp_address[46:15],
  // resp_length[62:47], resp_roundtrip[63], resp_packets[71:64], resp_flits[79:72]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  `include "fixed_latency_memory_responder_core_defines.svh"

  // The own node and application identifiers are accepted on the configuration port but
  // no output carries them, so their writes are dropped and no storage is kept for them.
  cfg_t    cfg_q, cfg_d;

  logic    front_valid;
  cmd_t    front_cmd;
  logic    queue_full;
  logic    queue_valid;
  cmd_t    queue_cmd;
  logic    queue_pop;

  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    out_free;
  logic    emit;
  result_t emit_result;
  status_t status;

  // Configuration register file.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LATENCY: cfg_d.latency = cfg_wdata_i[LAT_W-1:0];
        CFG_PACKETS: cfg_d.packets = cfg_wdata_i[7:0];
        CFG_FLITS:   cfg_d.flits   = cfg_wdata_i[7:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.latency <= LAT_W'(100);
      cfg_q.packets <= 8'd1;
      cfg_q.flits   <= 8'd1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: decode the operation and check the requester's level.
  flr_front u_front (
    .op_i        (s_axis_tuser_i),
    .data_i      (s_axis_tdata_i),
    .cmd_valid_o (front_valid),
    .cmd_o       (front_cmd)
  );

  // Any transaction is taken while the queue has room; the unused operation code is
  // taken as well and simply not queued.
  assign s_axis_tready_o = !queue_full;

  flr_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid_i && front_valid),
    .cmd_i   (front_cmd),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .cmd_o   (queue_cmd)
  );

  // The back end only starts a command when the output register is free by the end of the
  // cycle, so a result produced later in ST_TICK_RD or ST_CRED_RD still finds it empty.
  assign out_free = !out_valid_q || m_axis_tready_i;

  flr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (queue_valid),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (queue_pop),
    .out_free_i  (out_free),
    .emit_o      (emit),
    .result_o    (emit_result),
    .status_o    (status)
  );

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= emit_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {out_q.resp_flits, out_q.resp_packets, out_q.resp_roundtrip,
                            out_q.resp_length, out_q.resp_address, out_q.resp_l2_hit,
                            out_q.resp_kind, out_q.dst_app, out_q.dst_node};

  // Queued requests always have a running timer.
  `FLR_ASSERT_NOW(a_armed_when_pending, status.req_count != '0, status.armed,
                  "requests are queued while the latency timer is idle")

  // Credits are only saved when no response waits, and responses only queue without credits.
  `FLR_ASSERT_NOW(a_credit_xor_backlog, status.held != '0, status.resp_count == '0,
                  "credits are held while responses are waiting")

  // A response read from the response RAM must find the output register empty.
  `FLR_ASSERT_NOW(a_out_free_on_release, status.credit_read, !out_valid_q,
                  "released response would overwrite a pending output transaction")

  // Retiring the head request removes exactly one entry from the request queue.
  `FLR_ASSERT_NEXT(a_retire_pops_one, status.tick_read,
                   status.req_count == $past(status.req_count) - REQ_CW'(1),
                   "request queue count wrong after retiring the head request")

endmodule

// ===== sv/flr_ram.sv =====
module flr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// ===== sv/flr_front.sv =====
module flr_front import flr_pkg::*; (
  input  logic [1:0]            op_i,
  input  logic [IN_TDATA_W-1:0] data_i,
  output logic                  cmd_valid_o,
  output cmd_t                  cmd_o
);

  logic [2:0]  origin;
  logic [7:0]  node;
  logic [3:0]  app;
  logic [1:0]  kind;
  logic        l2_hit;
  logic [31:0] address;
  logic [15:0] length;
  logic        roundtrip;

  assign origin    = data_i[2:0];
  assign node      = data_i[10:3];
  assign app       = data_i[14:11];
  assign kind      = data_i[16:15];
  assign l2_hit    = data_i[17];
  assign address   = data_i[49:18];
  assign length    = data_i[65:50];
  assign roundtrip = data_i[66];

  // Requests from the wrong level are flagged here; the unused code is dropped.
  always_comb begin
    cmd_valid_o = 1'b1;
    cmd_o.word  = {roundtrip, l2_hit, kind, app, node, length, address};
    cmd_o.kind  = CMD_TICK;
    unique case (op_e'(op_i))
      OP_REQUEST: cmd_o.kind = (origin == ORIGIN_L2) ? CMD_REQ : CMD_BAD;
      OP_CREDIT:  cmd_o.kind = CMD_CREDIT;
      OP_TICK:    cmd_o.kind = CMD_TICK;
      default:    cmd_valid_o = 1'b0;
    endcase
  end

endmodule

// ===== sv/flr_cmd_queue.sv =====
module flr_cmd_queue import flr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t             mem_q [CQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [CQ_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CQ_CW-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (count_q == CQ_CW'(CQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== sv/flr_back.sv =====
module flr_back import flr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    out_free_i,
  output logic    emit_o,
  output result_t result_o,
  output status_t status_o
);

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_TICK_RD = 3'b010,
    ST_CRED_RD = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [REQ_AW-1:0]  req_head_q, req_head_d, req_tail_q, req_tail_d;
  logic [REQ_CW-1:0]  req_count_q, req_count_d;
  logic [RESP_AW-1:0] resp_head_q, resp_head_d, resp_tail_q, resp_tail_d;
  logic [RESP_CW-1:0] resp_count_q, resp_count_d;
  logic [CRED_W-1:0]  held_q, held_d;
  logic [LAT_W-1:0]   cd_q, cd_d;
  logic               armed_q, armed_d;

  logic               req_we;
  logic [REQ_AW-1:0]  req_addr;
  logic [WORD_W-1:0]  req_rdata;
  logic               resp_we;
  logic [RESP_AW-1:0] resp_addr;
  logic [WORD_W-1:0]  resp_rdata;

  logic [LAT_W-1:0]   arm_value;
  logic [LAT_W-1:0]   cd_dec;

  // A programmed latency of zero is replaced by 1 when the timer is armed.
  assign arm_value = (cfg_i.latency == '0) ? LAT_W'(1) : cfg_i.latency;
  assign cd_dec    = (cd_q == '0) ? '0 : cd_q - 1'b1;

  function automatic result_t plain_result(rk_e kind);
    result_t r;
    r      = '0;
    r.kind = kind;
    return r;
  endfunction

  function automatic result_t response(logic [WORD_W-1:0] w, cfg_t cfg);
    result_t r;
    r.kind           = RK_RESPONSE;
    r.dst_node       = w[55:48];
    r.dst_app        = w[59:56];
    r.resp_kind      = w[61:60];
    r.resp_l2_hit    = w[62];
    r.resp_address   = w[31:0];
    r.resp_length    = w[47:32];
    r.resp_roundtrip = w[63];
    r.resp_packets   = cfg.packets;
    r.resp_flits     = cfg.flits;
    return r;
  endfunction

  always_comb begin
    state_d      = state_q;
    req_head_d   = req_head_q;
    req_tail_d   = req_tail_q;
    req_count_d  = req_count_q;
    resp_head_d  = resp_head_q;
    resp_tail_d  = resp_tail_q;
    resp_count_d = resp_count_q;
    held_d       = held_q;
    cd_d         = cd_q;
    armed_d      = armed_q;
    req_we       = 1'b0;
    req_addr     = req_head_q;
    resp_we      = 1'b0;
    resp_addr    = resp_head_q;
    cmd_pop_o    = 1'b0;
    emit_o       = 1'b0;
    result_o     = plain_result(RK_CREDIT);

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && out_free_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_BAD: begin
              emit_o   = 1'b1;
              result_o = plain_result(RK_BAD_ORIGIN);
            end
            CMD_REQ: begin
              emit_o = 1'b1;
              if (req_count_q == REQ_CW'(REQ_DEPTH)) begin
                result_o = plain_result(RK_OVERFLOW);
              end else begin
                req_we      = 1'b1;
                req_addr    = req_tail_q;
                req_tail_d  = (req_tail_q == REQ_AW'(REQ_DEPTH - 1)) ? '0 : req_tail_q + 1'b1;
                req_count_d = req_count_q + 1'b1;
                if (!armed_q) begin
                  armed_d = 1'b1;
                  cd_d    = arm_value;
                end
              end
            end
            CMD_CREDIT: begin
              if (resp_count_q != '0) begin
                state_d = ST_CRED_RD;
              end else if (held_q != CRED_W'(MAX_CREDITS)) begin
                held_d = held_q + 1'b1;
              end
            end
            CMD_TICK: begin
              if (armed_q) begin
                cd_d = cd_dec;
                if (cd_dec == '0) begin
                  if (req_count_q == '0) begin
                    armed_d = 1'b0;
                  end else if (held_q != '0 || resp_count_q != RESP_CW'(RESP_DEPTH)) begin
                    state_d = ST_TICK_RD;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_TICK_RD: begin
        state_d     = ST_IDLE;
        req_head_d  = (req_head_q == REQ_AW'(REQ_DEPTH - 1)) ? '0 : req_head_q + 1'b1;
        req_count_d = req_count_q - 1'b1;
        if (held_q != '0) begin
          held_d   = held_q - 1'b1;
          emit_o   = 1'b1;
          result_o = response(req_rdata, cfg_i);
        end else begin
          resp_we      = 1'b1;
          resp_addr    = resp_tail_q;
          resp_tail_d  = (resp_tail_q == RESP_AW'(RESP_DEPTH - 1)) ? '0 : resp_tail_q + 1'b1;
          resp_count_d = resp_count_q + 1'b1;
        end
        if (req_count_q != REQ_CW'(1)) begin
          cd_d = arm_value;
        end else begin
          armed_d = 1'b0;
          cd_d    = '0;
        end
      end
      ST_CRED_RD: begin
        state_d      = ST_IDLE;
        resp_head_d  = (resp_head_q == RESP_AW'(RESP_DEPTH - 1)) ? '0 : resp_head_q + 1'b1;
        resp_count_d = resp_count_q - 1'b1;
        emit_o       = 1'b1;
        result_o     = response(resp_rdata, cfg_i);
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      req_head_q   <= '0;
      req_tail_q   <= '0;
      req_count_q  <= '0;
      resp_head_q  <= '0;
      resp_tail_q  <= '0;
      resp_count_q <= '0;
      held_q       <= '0;
      cd_q         <= '0;
      armed_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      req_head_q   <= req_head_d;
      req_tail_q   <= req_tail_d;
      req_count_q  <= req_count_d;
      resp_head_q  <= resp_head_d;
      resp_tail_q  <= resp_tail_d;
      resp_count_q <= resp_count_d;
      held_q       <= held_d;
      cd_q         <= cd_d;
      armed_q      <= armed_d;
    end
  end

  flr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (REQ_DEPTH)
  ) u_req_ram (
    .clk_i   (clk_i),
    .we_i    (req_we),
    .addr_i  (req_addr),
    .wdata_i (cmd_i.word),
    .rdata_o (req_rdata)
  );

  flr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RESP_DEPTH)
  ) u_resp_ram (
    .clk_i   (clk_i),
    .we_i    (resp_we),
    .addr_i  (resp_addr),
    .wdata_i (req_rdata),
    .rdata_o (resp_rdata)
  );

  assign status_o.req_count   = req_count_q;
  assign status_o.resp_count  = resp_count_q;
  assign status_o.held        = held_q;
  assign status_o.armed       = armed_q;
  assign status_o.tick_read   = (state_q == ST_TICK_RD);
  assign status_o.credit_read = (state_q == ST_CRED_RD);

endmodule

// ===== bench/fixed_latency_memory_responder_core_tb.sv =====
// Self-checking bench for the fixed latency memory responder.
//
// Every input transaction that the block accepts is fed to a behavioural copy of the
// responder kept in this module: the queue of pending requests, the queue of parked
// responses, the saved output credits and the latency timer. What that copy says the
// transaction causes (at most one output transaction) is appended to a list of awaited
// results, and every output transaction is compared with the oldest entry of that list.
//
// The run starts with a short hand-written plan (a table walked by a loop), then eight random
// phases with different register settings, request and credit mixes and back-pressure
// patterns, and finally a credit flood that drives the saved credit count into saturation.
module fixed_latency_memory_responder_core_tb;
  import flr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any accepted transaction before the run is declared hung. The long
  // receiver hold-off below is the longest quiet stretch that a correct run contains.
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  // Cycles allowed for commands that cause no result to drain through the command queue.
  localparam int SETTLE      = 16;
  localparam int PHASE_ITEMS = 60;
  // First register index beyond the list; writes there must have no effect.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(CFG_FLITS + 1);

  // Input data word, first field in the lowest bits.
  typedef struct packed {
    logic [4:0]  pad;
    logic        roundtrip;
    logic [15:0] len;
    logic [31:0] addr;
    logic        l2_hit;
    logic [1:0]  kind;
    logic [3:0]  app;
    logic [7:0]  node;
    logic [2:0]  origin;
  } req_fields_t;

  // Output data word, first field in the lowest bits.
  typedef struct packed {
    logic [7:0]  flits;
    logic [7:0]  packets;
    logic        roundtrip;
    logic [15:0] len;
    logic [31:0] addr;
    logic        l2_hit;
    logic [1:0]  kind;
    logic [3:0]  app;
    logic [7:0]  node;
  } resp_fields_t;

  typedef struct packed {
    rk_e          kind;
    resp_fields_t f;
  } outcome_t;

  // One row of the hand-written plan: either a register write or a run of identical
  // input transactions, optionally with the result kind written out by hand.
  typedef struct packed {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          value;
    op_e                  op;
    req_fields_t          fields;
    int                   reps;
    bit                   typed;
    rk_e                  kind;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  op_e                   s_tuser = OP_NONE;
  req_fields_t           s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [1:0]            m_tuser;
  logic [OUT_TDATA_W-1:0] m_tdata;

  // Idling percentages of the current phase, and the one-off receiver hold-off.
  int gap_pct = 0;
  int stall_pct = 0;
  bit pressure_req = 1'b0;
  bit pressure_done = 1'b0;

  int fault_count = 0;
  outcome_t awaited_q[$];
  plan_row_t directed_plan[$];

  // Behavioural copy of the responder state and registers.
  req_fields_t pending_reqs[$];
  req_fields_t parked_resps[$];
  int          spare_credits = 0;
  logic [15:0] timer = '0;
  bit          timer_on = 1'b0;
  logic [15:0] lat_cfg = 16'd100;
  logic [7:0]  node_cfg = '0;
  logic [3:0]  app_cfg = '0;
  logic [7:0]  packets_cfg = 8'd1;
  logic [7:0]  flits_cfg = 8'd1;

  fixed_latency_memory_responder_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] arm_value();
    // A zero latency setting is replaced by 1 when the timer is armed.
    return (lat_cfg == 16'd0) ? 16'd1 : lat_cfg;
  endfunction

  // Packets and flits are taken from the registers as they stand when the response leaves.
  function automatic outcome_t make_response(req_fields_t r);
    outcome_t o;
    o = '0;
    o.kind        = RK_RESPONSE;
    o.f.node      = r.node;
    o.f.app       = r.app;
    o.f.kind      = r.kind;
    o.f.l2_hit    = r.l2_hit;
    o.f.addr      = r.addr;
    o.f.len       = r.len;
    o.f.roundtrip = r.roundtrip;
    o.f.packets   = packets_cfg;
    o.f.flits     = flits_cfg;
    return o;
  endfunction

  // Advances the behavioural copy by one input transaction and returns the result it causes.
  task automatic predict_outcome(input op_e op, input req_fields_t f, output bit has,
                                 output outcome_t o);
    req_fields_t head;
    has = 1'b0;
    o = '0;
    case (op)
      OP_REQUEST: begin
        has = 1'b1;
        if (f.origin != ORIGIN_L2) begin
          // A request from the wrong level is dropped without touching any state.
          o.kind = RK_BAD_ORIGIN;
        end else if (pending_reqs.size() >= REQ_DEPTH) begin
          o.kind = RK_OVERFLOW;
        end else begin
          pending_reqs.push_back(f);
          if (!timer_on) begin
            timer_on = 1'b1;
            timer = arm_value();
          end
          o.kind = RK_CREDIT;
        end
      end
      OP_CREDIT: begin
        if (parked_resps.size() > 0) begin
          has = 1'b1;
          o = make_response(parked_resps.pop_front());
        end else if (spare_credits < MAX_CREDITS) begin
          spare_credits++;
        end
      end
      OP_TICK: begin
        // A tick with the timer idle does nothing at all.
        if (timer_on) begin
          if (timer > 0) timer--;
          if (timer == 0) begin
            if (pending_reqs.size() == 0) begin
              timer_on = 1'b0;
            end else if (spare_credits != 0 || parked_resps.size() < RESP_DEPTH) begin
              // Otherwise the response queue is full with no credit: the timer stays at
              // zero and the next tick tries again.
              head = pending_reqs.pop_front();
              if (spare_credits > 0) begin
                spare_credits--;
                has = 1'b1;
                o = make_response(head);
              end else begin
                parked_resps.push_back(head);
              end
              if (pending_reqs.size() > 0) begin
                timer = arm_value();
              end else begin
                timer_on = 1'b0;
                timer = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic req_fields_t random_request();
    logic [95:0] raw;
    req_fields_t f;
    raw = {$urandom, $urandom, $urandom};
    f = raw[71:0];
    f.pad = '0;
    // Most requests come from the right level so that they get past the origin check.
    if ($urandom_range(99) < 85) f.origin = ORIGIN_L2;
    return f;
  endfunction

  function automatic string describe(outcome_t o);
    return $sformatf("kind %0d node %h app %h rw %h l2 %b addr %h len %h rt %b pk %h fl %h",
                     o.kind, o.f.node, o.f.app, o.f.kind, o.f.l2_hit, o.f.addr, o.f.len,
                     o.f.roundtrip, o.f.packets, o.f.flits);
  endfunction

  task automatic plan_item(input op_e op, input logic [2:0] origin, input bit fill,
                           input int reps, input bit typed, input rk_e kind);
    plan_row_t r;
    r = '0;
    r.op = op;
    r.fields = fill ? '1 : '0;
    r.fields.pad = '0;
    r.fields.origin = origin;
    r.reps = reps;
    r.typed = typed;
    r.kind = kind;
    directed_plan.push_back(r);
  endtask

  task automatic plan_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.value = value;
    directed_plan.push_back(r);
  endtask

  // Offers one input transaction. It is entered just after a falling edge and returns just
  // after the falling edge that follows acceptance, with tvalid still high, so that the
  // next transaction can follow back to back without tvalid being dropped in between.
  task automatic offer(input op_e op, input req_fields_t f, input bit typed = 1'b0,
                       input rk_e typed_kind = RK_CREDIT);
    bit has;
    outcome_t o;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= f;
    do @(posedge clk); while (!s_tready);
    predict_outcome(op, f, has, o);
    if (typed) begin
      awaited_q.push_back('{kind: typed_kind, f: '0});
    end else if (has) begin
      awaited_q.push_back(o);
    end
    @(negedge clk);
  endtask

  // Waits until every awaited result has arrived and the commands that cause no result have
  // had time to drain, so that registers can be written with the block idle.
  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_LATENCY: lat_cfg = value;
      CFG_NODE:    node_cfg = value[7:0];
      CFG_APP:     app_cfg = value[3:0];
      CFG_PACKETS: packets_cfg = value[7:0];
      CFG_FLITS:   flits_cfg = value[7:0];
      default: ;
    endcase
  endtask

  // Receiver: ready changes at falling edges only. Once during the pressure phase it holds
  // off for a long stretch so that the command queue fills and the input side stalls.
  initial begin
    forever begin
      @(negedge clk);
      if (pressure_req && !pressure_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        pressure_done = 1'b1;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Result checker: each accepted output transaction against the oldest awaited result.
  outcome_t seen;
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      seen.kind = rk_e'(m_tuser);
      seen.f = m_tdata;
      if (awaited_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result: %s", describe(seen));
      end else begin
        if (seen !== awaited_q[0]) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected %s", describe(awaited_q[0]));
            $display("          actual   %s", describe(seen));
          end
        end
        void'(awaited_q.pop_front());
      end
    end
  end

  // Watchdog: ends the run when no transaction has been accepted for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int k;
    int w_req;
    int w_cred;
    int pick;
    op_e op;
    req_fields_t f;
    logic [15:0] lat_pick;

    // Hand-written plan, starting from the reset settings (latency register at its reset value,
    // one packet of one flit per response).
    plan_item(OP_TICK,    ORIGIN_L2, 1'b0, 1,  1'b0, RK_CREDIT);     // idle timer
    plan_item(OP_NONE,    ORIGIN_L2, 1'b1, 1,  1'b0, RK_CREDIT);     // unknown operation
    plan_item(OP_CREDIT,  ORIGIN_L2, 1'b0, 1,  1'b0, RK_CREDIT);     // saved credit
    plan_item(OP_REQUEST, 3'd0,      1'b1, 1,  1'b1, RK_BAD_ORIGIN);
    plan_item(OP_REQUEST, 3'd7,      1'b0, 1,  1'b1, RK_BAD_ORIGIN);
    plan_item(OP_REQUEST, ORIGIN_L2, 1'b1, 1,  1'b1, RK_CREDIT);
    plan_item(OP_TICK,    ORIGIN_L2, 1'b0, 99, 1'b0, RK_CREDIT);
    plan_item(OP_TICK,    ORIGIN_L2, 1'b1, 1,  1'b0, RK_CREDIT);     // expiry uses the credit
    plan_cfg(CFG_LATENCY, 16'd0);                                   // replaced by 1 when armed
    plan_cfg(CFG_PACKETS, 16'd255);
    plan_cfg(CFG_FLITS,   16'd255);
    plan_item(OP_REQUEST, ORIGIN_L2, 1'b0, 16, 1'b1, RK_CREDIT);     // request queue full
    plan_item(OP_REQUEST, ORIGIN_L2, 1'b1, 1,  1'b1, RK_OVERFLOW);
    plan_item(OP_TICK,    ORIGIN_L2, 1'b0, 16, 1'b0, RK_CREDIT);     // response queue full
    plan_item(OP_REQUEST, ORIGIN_L2, 1'b1, 1,  1'b1, RK_CREDIT);
    plan_item(OP_TICK,    ORIGIN_L2, 1'b1, 2,  1'b0, RK_CREDIT);     // stalled expiry
    plan_item(OP_CREDIT,  ORIGIN_L2, 1'b1, 1,  1'b0, RK_CREDIT);
    plan_item(OP_TICK,    ORIGIN_L2, 1'b0, 1,  1'b0, RK_CREDIT);
    plan_item(OP_CREDIT,  ORIGIN_L2, 1'b0, 17, 1'b0, RK_CREDIT);
    plan_cfg(CFG_NODE, 16'd255);
    plan_cfg(CFG_APP,  16'd15);
    plan_cfg(CFG_SPARE, 16'hFFFF);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i]) begin
      if (directed_plan[i].is_cfg) begin
        wait_quiet();
        write_reg(directed_plan[i].idx, directed_plan[i].value);
      end else begin
        repeat (directed_plan[i].reps)
          offer(directed_plan[i].op, directed_plan[i].fields, directed_plan[i].typed,
                directed_plan[i].kind);
      end
    end

    // Random phases. Each one starts from an idle block with fresh register values, and
    // the mix of requests and credits decides which queues fill up.
    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 73; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 73; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      case (p)
        0: begin lat_pick = 16'd1; w_req = 30; w_cred = 25; end
        1: begin lat_pick = 16'd0; w_req = 45; w_cred = 10; end
        2: begin lat_pick = 16'd2; w_req = 25; w_cred = 5;  end
        3: begin lat_pick = 16'($urandom_range(1, 6)); w_req = 30; w_cred = 30; end
        4: begin lat_pick = 16'd1; w_req = 20; w_cred = 40; end
        5: begin lat_pick = 16'd3; w_req = 40; w_cred = 25; end
        6: begin lat_pick = 16'($urandom_range(1, 4)); w_req = 50; w_cred = 5; end
        default: begin lat_pick = 16'd8; w_req = 30; w_cred = 20; end
      endcase
      write_reg(CFG_LATENCY, lat_pick);
      write_reg(CFG_PACKETS, (p == 2) ? 16'd1 : (p == 4) ? 16'd255 :
                             16'($urandom_range(1, 255)));
      write_reg(CFG_FLITS,   (p == 2) ? 16'd255 : (p == 4) ? 16'd1 :
                             16'($urandom_range(1, 255)));
      write_reg(CFG_NODE, (p == 6) ? 16'd0 : 16'($urandom_range(0, 255)));
      write_reg(CFG_APP,  (p == 6) ? 16'd0 : 16'($urandom_range(0, 15)));
      if (p == 3) begin
        for (k = CFG_SPARE; k < (1 << CFG_IDX_W); k++) write_reg(CFG_IDX_W'(k), 16'($urandom));
      end
      if (p == 5) begin
        // The long receiver hold-off runs while the sender keeps offering at full rate.
        gap_pct = 0;
        stall_pct = 0;
        pressure_req = 1'b1;
      end
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < w_req) op = OP_REQUEST;
        else if (pick < w_req + w_cred) op = OP_CREDIT;
        else if (pick < 99) op = OP_TICK;
        else op = OP_NONE;
        offer(op, random_request());
      end
    end

    // Credit flood: more credits than can be saved, then more responses than the saved
    // credits cover, so the last few are parked until fresh credits arrive.
    wait_quiet();
    gap_pct = 0;
    stall_pct = 15;
    write_reg(CFG_LATENCY, 16'd1);
    repeat (270) offer(OP_CREDIT, random_request());
    repeat (262) begin
      f = random_request();
      f.origin = ORIGIN_L2;
      offer(OP_REQUEST, f);
      offer(OP_TICK, random_request());
    end
    while (pending_reqs.size() != 0 || parked_resps.size() != 0) begin
      offer(OP_CREDIT, random_request());
      offer(OP_TICK, random_request());
    end

    s_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/flr_pkg.sv
sv/flr_ram.sv
sv/flr_front.sv
sv/flr_cmd_queue.sv
sv/flr_back.sv
sv/fixed_latency_memory_responder_core.sv
bench/fixed_latency_memory_responder_core_tb.sv
